FILE: src/sdds_pkg.sv
// ----------------------------------------------------------------------------
// sdds_pkg
// Shared types, register codes and the quarter-wave sine table generator
// of the sine oscillator.
// ----------------------------------------------------------------------------
package sdds_pkg;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned FREQ_BITS      = 32;
    localparam int unsigned AMPL_BITS      = 16;
    localparam int unsigned AMPL_FRAC      = 15;

    localparam logic [FREQ_BITS-1:0] FREQ_RESET = 32'd39370535;
    localparam logic [AMPL_BITS-1:0] AMPL_RESET = 16'd8192;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_FREQUENCY = 2'd1,
        CFG_AMPLITUDE = 2'd2
    } cfg_index_t;

    // Control that travels with a table read.
    typedef struct packed {
        logic active;
        logic neg;
    } lookup_ctrl_t;

    // Load enables of the scaling stages.
    typedef struct packed {
        logic ld2;
        logic ld3;
    } stage_load_t;

    // Divides a Taylor term by (2n)(2n+1).
    function automatic logic [63:0] div_term(input logic [63:0] v, input int n);
        case (n)
            1:       return v / 64'd6;
            2:       return v / 64'd20;
            3:       return v / 64'd42;
            4:       return v / 64'd72;
            5:       return v / 64'd110;
            6:       return v / 64'd156;
            7:       return v / 64'd210;
            8:       return v / 64'd272;
            9:       return v / 64'd342;
            10:      return v / 64'd420;
            11:      return v / 64'd506;
            12:      return v / 64'd600;
            13:      return v / 64'd702;
            14:      return v / 64'd812;
            15:      return v / 64'd930;
            default: return v;
        endcase
    endfunction

    // Sine of a Q30 angle as a truncated Q30 Taylor series, clamped to [0, 1].
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = signed'(x);
        for (int n = 1; n < 16; n++) begin
            if (term != 64'd0) begin
                term = div_term((term * x2) >> 30, n);
                if ((n & 1) == 1) begin
                    acc = acc - signed'(term);
                end else begin
                    acc = acc + signed'(term);
                end
            end
        end
        if (acc < 0) begin
            acc = 64'sd0;
        end
        if (unsigned'(acc) > ONE_Q30) begin
            acc = signed'(ONE_Q30);
        end
        return unsigned'(acc);
    endfunction

    // Entry idx of the quarter-wave table, evaluated at elaboration.
    function automatic logic [31:0] table_entry(input int unsigned idx,
                                                input int unsigned addr_bits,
                                                input int unsigned sample_bits);
        logic [63:0] fs;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        fs = (64'd1 << (sample_bits - 1)) - 64'd1;
        x  = (HALF_PI_Q30 * 64'(idx) + ((64'd1 << addr_bits) >> 1)) >> addr_bits;
        s  = sine_q30(x);
        v  = (s * fs + (ONE_Q30 >> 1)) >> 30;
        if (v > fs) begin
            v = fs;
        end
        return v[31:0];
    endfunction

endpackage

FILE: src/sine_oscillator_dds.sv
// ----------------------------------------------------------------------------
// sine_oscillator_dds: sine tone generator, one sample per input transaction.
// Registered stages to output valid: table read, amplitude multiply, round and
// saturate. One transaction per cycle while the output is not stalled.
// Reset clears the phase and pipeline; enable 0, default tone and gain.
// ----------------------------------------------------------------------------
module sine_oscillator_dds #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [sdds_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [sdds_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  restart,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]         sample
);

    logic                                enable_reg;
    logic [sdds_pkg::FREQ_BITS-1:0]      freq_reg;
    logic [sdds_pkg::AMPL_BITS-1:0]      ampl_reg;

    logic                                v1_reg;
    logic                                v2_reg;
    logic                                v3_reg;
    logic                                ld1;
    logic                                accept;
    sdds_pkg::stage_load_t               load;

    logic [TABLE_ADDR_BITS:0]            lookup_addr;
    sdds_pkg::lookup_ctrl_t              lookup_ctrl;
    sdds_pkg::lookup_ctrl_t              ctrl1_reg;
    logic [SAMPLE_BITS-2:0]              tbl_data;
    logic [PHASE_BITS-1:0]               phase;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            freq_reg   <= sdds_pkg::FREQ_RESET;
            ampl_reg   <= sdds_pkg::AMPL_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                sdds_pkg::CFG_ENABLE:    enable_reg <= cfg_data[0];
                sdds_pkg::CFG_FREQUENCY: freq_reg   <= cfg_data[sdds_pkg::FREQ_BITS-1:0];
                sdds_pkg::CFG_AMPLITUDE: ampl_reg   <= cfg_data[sdds_pkg::AMPL_BITS-1:0];
                default:                 ;
            endcase
        end
    end

    // Each stage loads when it is empty or its content moves on.
    assign load.ld3 = !v3_reg || !out_stall;
    assign load.ld2 = !v2_reg || load.ld3;
    assign ld1      = !v1_reg || load.ld2;
    assign in_stall = !ld1;
    assign accept   = in_valid && ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (load.ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (load.ld3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            ctrl1_reg <= lookup_ctrl;
        end
    end

    sdds_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .restart     (restart),
        .enable      (enable_reg),
        .freq_word   (freq_reg),
        .lookup_addr (lookup_addr),
        .lookup_ctrl (lookup_ctrl),
        .phase       (phase)
    );

    sdds_rom #(
        .ADDR_BITS   (TABLE_ADDR_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .clk     (clk),
        .rd_en   (ld1),
        .rd_addr (lookup_addr),
        .rd_data (tbl_data)
    );

    sdds_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk       (clk),
        .load      (load),
        .tbl_data  (tbl_data),
        .ctrl_in   (ctrl1_reg),
        .amplitude (ampl_reg),
        .sample    (sample)
    );

    assign out_valid = v3_reg;

    // The input side stalls only when every stage holds a transaction.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && out_stall))
        else $error("input stalled while the pipeline has room");

    // A disabled oscillator keeps its phase unless restarted.
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !enable_reg && !restart) |=> $stable(phase))
        else $error("phase moved while disabled");

    // After a restart the phase is one tuning step from zero, or zero.
    a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart && !cfg_write_en) |=>
            (phase == (enable_reg ? PHASE_BITS'(freq_reg) : '0)))
        else $error("restart did not clear the phase");

    // Nothing enters the pipeline without an input transaction.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (ld1 && !in_valid) |=> !v1_reg)
        else $error("first stage became valid without a transaction");

endmodule

FILE: src/sdds_rom.sv
// ----------------------------------------------------------------------------
// sdds_rom
// Quarter-wave sine table, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdds_rom #(
    parameter int ADDR_BITS   = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [ADDR_BITS:0]     rd_addr,
    output logic [SAMPLE_BITS-2:0] rd_data
);

    localparam int DEPTH = (1 << ADDR_BITS) + 1;
    localparam int WIDTH = SAMPLE_BITS - 1;

    logic [WIDTH-1:0] rom_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        assign rom_mem[i] = WIDTH'(sdds_pkg::table_entry(i, ADDR_BITS, SAMPLE_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/sdds_phase.sv
// ----------------------------------------------------------------------------
// sdds_phase
// Phase accumulator and quadrant folding of the phase into a table address.
// ----------------------------------------------------------------------------
module sdds_phase #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                restart,
    input  logic                                enable,
    input  logic [sdds_pkg::FREQ_BITS-1:0]      freq_word,
    output logic [TABLE_ADDR_BITS:0]            lookup_addr,
    output sdds_pkg::lookup_ctrl_t              lookup_ctrl,
    output logic [PHASE_BITS-1:0]               phase
);

    localparam logic [TABLE_ADDR_BITS:0] TBL_N = (TABLE_ADDR_BITS + 1)'(1) << TABLE_ADDR_BITS;

    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [PHASE_BITS-1:0]      cur_phase;
    logic [PHASE_BITS-1:0]      step;
    logic [1:0]                 quadrant;
    logic [TABLE_ADDR_BITS:0]   k_ext;

    // The tuning word is taken modulo the phase range.
    assign step      = PHASE_BITS'(freq_word);
    assign cur_phase = restart ? '0 : phase_reg;
    assign quadrant  = cur_phase[PHASE_BITS-1 -: 2];
    assign k_ext     = {1'b0, cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS]};

    // Odd quadrants run the table backward.
    assign lookup_addr        = quadrant[0] ? (TBL_N - k_ext) : k_ext;
    assign lookup_ctrl.neg    = quadrant[1];
    assign lookup_ctrl.active = enable;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = enable ? (cur_phase + step) : cur_phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

FILE: src/sdds_scale.sv
// ----------------------------------------------------------------------------
// sdds_scale
// Amplitude multiply, rounding, sign restore and saturation of the sample.
// ----------------------------------------------------------------------------
module sdds_scale #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  sdds_pkg::stage_load_t             load,
    input  logic [SAMPLE_BITS-2:0]            tbl_data,
    input  sdds_pkg::lookup_ctrl_t            ctrl_in,
    input  logic [sdds_pkg::AMPL_BITS-1:0]    amplitude,
    output logic signed [SAMPLE_BITS-1:0]     sample
);

    localparam int PROD_BITS = SAMPLE_BITS - 1 + sdds_pkg::AMPL_BITS;
    localparam int MAG_BITS  = PROD_BITS + 1 - sdds_pkg::AMPL_FRAC;
    localparam logic [PROD_BITS:0] ROUND_HALF =
        (PROD_BITS + 1)'(1) << (sdds_pkg::AMPL_FRAC - 1);
    localparam logic [MAG_BITS-1:0] FS_MAG  = (MAG_BITS'(1) << (SAMPLE_BITS - 1)) - MAG_BITS'(1);
    localparam logic [SAMPLE_BITS-1:0] FS_VAL  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_VAL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [PROD_BITS-1:0]        prod_reg;
    sdds_pkg::lookup_ctrl_t      ctrl_reg;
    logic [PROD_BITS:0]          rounded;
    logic [MAG_BITS-1:0]         mag;
    logic [MAG_BITS-1:0]         mag_neg;
    logic [SAMPLE_BITS-1:0]      sample_next;
    logic [SAMPLE_BITS-1:0]      sample_reg;

    always_ff @(posedge clk)
    begin
        if (load.ld2)
        begin
            prod_reg <= PROD_BITS'(tbl_data) * PROD_BITS'(amplitude);
            ctrl_reg <= ctrl_in;
        end
    end

    assign rounded = {1'b0, prod_reg} + ROUND_HALF;
    assign mag     = rounded[PROD_BITS -: MAG_BITS];
    assign mag_neg = -mag;

    // A negative result may reach one step further than a positive one.
    always_comb
    begin
        if (!ctrl_reg.active)
        begin
            sample_next = '0;
        end
        else if (!ctrl_reg.neg)
        begin
            sample_next = (mag > FS_MAG) ? FS_VAL : mag[SAMPLE_BITS-1:0];
        end
        else
        begin
            sample_next = (mag > FS_MAG + MAG_BITS'(1)) ? MIN_VAL : mag_neg[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.ld3)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = signed'(sample_reg);

endmodule

FILE: bench/tb_sine_oscillator_dds.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_oscillator_dds
// Self-checking bench for the sine oscillator. Each input transaction is one
// sample tick. A behavioral phase accumulator and quarter-wave table predict
// every sample, and a monitor compares the output stream in order.
// ----------------------------------------------------------------------------
module tb_sine_oscillator_dds;

    localparam int              LATENCY      = 3;
    localparam int              QW_SIZE      = 1024;
    localparam int              FULL_SCALE   = 32767;
    localparam longint unsigned QUARTER_TURN = 64'd1686629713;
    localparam longint unsigned Q30_ONE      = 64'd1 << 30;
    localparam logic [1:0]      CFG_UNMAPPED = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write_en;
    logic [sdds_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [sdds_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     restart;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [15:0]       sample;

    // Behavioral copy of the oscillator state and its registers.
    int                       quarter_wave [QW_SIZE+1];
    logic                     tone_on;
    logic [31:0]              tune_word;
    logic [15:0]              gain;
    logic [31:0]              phase_acc;

    logic signed [15:0]       expected_samples [$];
    logic signed [15:0]       want_sample;
    int                       fail_count;
    int                       src_idle_pct;
    int                       sink_stall_pct;

    sine_oscillator_dds u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Works out the sample of one tick and advances the phase when the tone is on.
    function automatic logic signed [15:0] next_dds_sample(input logic clear_phase);
        int     tab;
        longint scaled;
        scaled = 0;
        if (clear_phase)
            phase_acc = '0;
        if (tone_on)
        begin
            tab    = phase_acc[30] ? quarter_wave[QW_SIZE - phase_acc[29:20]]
                                   : quarter_wave[phase_acc[29:20]];
            scaled = (longint'(tab) * longint'(gain) + 16384) >>> 15;
            if (phase_acc[31])
                scaled = -scaled;
            if (scaled > FULL_SCALE)
                scaled = FULL_SCALE;
            if (scaled < -FULL_SCALE - 1)
                scaled = -FULL_SCALE - 1;
            phase_acc = phase_acc + tune_word;
        end
        return scaled[15:0];
    endfunction

    // Drives one tick and holds it until the block takes it; valid stays
    // high on return so that back-to-back transactions need no gap.
    task automatic send_tick(input logic clear_phase);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < 16)
            gap++;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom_range(1));
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= clear_phase;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_samples.push_back(next_dds_sample(clear_phase));
    endtask

    task automatic stop_ticks();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        cfg_data     <= $urandom;
        case (idx)
            sdds_pkg::CFG_ENABLE:    tone_on   = data[0];
            sdds_pkg::CFG_FREQUENCY: tune_word = data;
            sdds_pkg::CFG_AMPLITUDE: gain      = data[15:0];
            default:                 ;
        endcase
    endtask

    task automatic program_tone(input logic [31:0] en_word, input logic [31:0] freq_word,
                                input logic [31:0] ampl_word);
        write_reg(sdds_pkg::CFG_ENABLE, en_word);
        write_reg(sdds_pkg::CFG_FREQUENCY, freq_word);
        write_reg(sdds_pkg::CFG_AMPLITUDE, ampl_word);
    endtask

    // Silence while disabled, then the default tone and gain left by reset.
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        stop_ticks();
        wait_drained();
        write_reg(sdds_pkg::CFG_ENABLE, 32'd1);
        repeat (4) send_tick(1'b0);
        stop_ticks();
        wait_drained();
    endtask

    // Quarter-turn steps at full scale land on each quadrant boundary.
    task automatic test_quadrants();
        program_tone(32'd1, 32'h4000_0000, 32'h0000_8000);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        stop_ticks();
        wait_drained();
    endtask

    // Maximum gain drives the peaks past both rails.
    task automatic test_saturation();
        program_tone(32'd1, 32'h2000_0000, 32'h0000_FFFF);
        send_tick(1'b1);
        repeat (7) send_tick(1'b0);
        stop_ticks();
        wait_drained();
    endtask

    // Tuning words above half the phase range alias; upper data bits of the
    // gain register are dropped.
    task automatic test_aliasing();
        program_tone(32'd1, 32'hFFFF_FFFF, 32'hABCD_8000);
        send_tick(1'b0);
        send_tick(1'b0);
        stop_ticks();
        wait_drained();
        write_reg(sdds_pkg::CFG_FREQUENCY, 32'h8000_0000);
        write_reg(sdds_pkg::CFG_AMPLITUDE, 32'd0);
        send_tick(1'b0);
        stop_ticks();
        wait_drained();
    endtask

    // A restart while disabled still clears the phase. Writes to the unused
    // register index must leave every setting alone.
    task automatic test_restart_disabled();
        program_tone(32'h0000_0002, 32'h1234_5678, 32'h0000_6000);
        send_tick(1'b1);
        stop_ticks();
        wait_drained();
        write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
        write_reg(sdds_pkg::CFG_ENABLE, 32'hFFFF_FFFF);
        send_tick(1'b0);
        send_tick(1'b0);
        stop_ticks();
        wait_drained();
    endtask

    task automatic test_random_tones();
        int          n_phase;
        int          k;
        logic [31:0] freq_word;
        logic [15:0] ampl;
        for (n_phase = 0; n_phase < 8; n_phase++)
        begin
            case (n_phase % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 47;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 47;
                end
                default:
                begin
                    src_idle_pct   = 6;
                    sink_stall_pct = 6;
                end
            endcase
            case ($urandom_range(5))
                0:       freq_word = $urandom_range(1, 1 << 22);
                1:       freq_word = 32'h8000_0000;
                2:       freq_word = 32'hFFFF_FFFF;
                3:       freq_word = 32'd0;
                default: freq_word = $urandom;
            endcase
            case ($urandom_range(7))
                0:       ampl = 16'd0;
                1:       ampl = 16'h8000;
                2:       ampl = 16'hFFFF;
                3:       ampl = 16'($urandom_range(32769, 65535));
                default: ampl = 16'($urandom_range(0, 32768));
            endcase
            program_tone({31'($urandom), 1'($urandom_range(9) != 0)}, freq_word,
                         {16'($urandom), ampl});
            for (k = 0; k < 60; k++)
            begin
                send_tick($urandom_range(99) < 4);
                // Let the pipeline empty completely once in the middle of a run.
                if (n_phase == 1 && k == 30)
                begin
                    stop_ticks();
                    wait_drained();
                end
            end
            stop_ticks();
            wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample: no transaction expected, actual %0d", sample);
                fail_count++;
            end
            else
            begin
                want_sample = expected_samples.pop_front();
                if (sample !== want_sample)
                begin
                    $error("sample: expected %0d, actual %0d", want_sample, sample);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned divisor;
        longint          acc;
        longint unsigned level;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        restart        = 1'b0;
        fail_count     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;

        // Quarter-wave table from a truncated Q30 Taylor series of the sine.
        for (int i = 0; i <= QW_SIZE; i++)
        begin
            ang    = (QUARTER_TURN * longint'(i) + (QW_SIZE >> 1)) >> 10;
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = longint'(ang);
            for (int n = 1; n < 16 && term != 0; n++)
            begin
                divisor = (2 * n) * (2 * n + 1);
                term    = ((term * ang_sq) >> 30) / divisor;
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            if (acc > longint'(Q30_ONE))
                acc = longint'(Q30_ONE);
            level = (longint'(acc) * FULL_SCALE + (Q30_ONE >> 1)) >> 30;
            if (level > FULL_SCALE)
                level = FULL_SCALE;
            quarter_wave[i] = int'(level);
        end

        tone_on   = 1'b0;
        tune_word = sdds_pkg::FREQ_RESET;
        gain      = sdds_pkg::AMPL_RESET;
        phase_acc = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_quadrants();
        test_saturation();
        test_aliasing();
        test_restart_disabled();
        test_random_tones();

        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_samples.size() != 0)
        begin
            $error("sample: %0d expected transactions never arrived",
                   expected_samples.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/sdds_pkg.sv
src/sdds_rom.sv
src/sdds_phase.sv
src/sdds_scale.sv
src/sine_oscillator_dds.sv
bench/tb_sine_oscillator_dds.sv
